[sv/sht_pkg.sv]
package sht_pkg;

  // Widths of the register file and of the item fields
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned DurW      = 24;
  localparam int unsigned DurExtW   = 32;

  // Defaults for the top-level parameters
  localparam int unsigned WAIT_WIDTH_DEF   = 24;
  localparam int unsigned RESET_PULSES_DEF = 9;

  // Register reset values
  localparam logic [HalfW-1:0] HALF_BIT_RST = 16'd64;
  localparam logic [DurW-1:0]  ACK_WAIT_RST = 24'd8000000;
  localparam logic [DurW-1:0]  CONV_RST     = 24'd16000;
  localparam logic [DurW-1:0]  SETTLE_RST   = 24'd9600000;
  localparam logic [DurW-1:0]  RWAIT_RST    = 24'd3200000;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_BIT   = 3'd0,
    REG_ACK_WAIT   = 3'd1,
    REG_CONV_WAIT  = 3'd2,
    REG_SETTLE     = 3'd3,
    REG_RESET_WAIT = 3'd4
  } cfg_reg_e;

  // Operation codes carried by func
  typedef enum logic [1:0] {
    FUNC_NONE    = 2'd0,
    FUNC_MEASURE = 2'd1,
    FUNC_REG_WR  = 2'd2,
    FUNC_CMD     = 2'd3
  } func_e;

  typedef struct packed {
    logic [HalfW-1:0] half_bit_ticks;
    logic [DurW-1:0]  ack_wait_ticks;
    logic [DurW-1:0]  convert_wait_ticks;
    logic [DurW-1:0]  settle_wait_ticks;
    logic [DurW-1:0]  reset_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cmd_byte;
    logic [7:0] param_byte;
    logic       data_in;
  } in_t;

  typedef struct packed {
    logic        sck;
    logic        data_out;
    logic        data_oe;
    logic        busy_res;
    logic        done_res;
    logic [15:0] result_value;
    logic [7:0]  check_byte;
    logic        ack_error;
  } res_t;

endpackage

[sv/sht_in_if.sv]
interface sht_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] cmd_byte;
  logic [7:0] param_byte;
  logic       data_in;

  modport source (output valid, func, cmd_byte, param_byte, data_in, input ready);
  modport sink   (input valid, func, cmd_byte, param_byte, data_in, output ready);
endinterface

[sv/sht_out_if.sv]
interface sht_out_if;
  logic        valid;
  logic        ready;
  logic        sck;
  logic        data_out;
  logic        data_oe;
  logic        busy_res;
  logic        done_res;
  logic [15:0] result_value;
  logic [7:0]  check_byte;
  logic        ack_error;

  modport source (output valid, sck, data_out, data_oe, busy_res, done_res, result_value,
                  check_byte, ack_error, input ready);
  modport sink   (input valid, sck, data_out, data_oe, busy_res, done_res, result_value,
                  check_byte, ack_error, output ready);
endinterface

[sv/sht_cfg.sv]
module sht_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sht_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sht_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output sht_pkg::cfg_t                  cfg_o
);

  sht_pkg::cfg_t cfg_q, cfg_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sht_pkg::cfg_reg_e'(cfg_idx_i))
        sht_pkg::REG_HALF_BIT:   cfg_d.half_bit_ticks     = cfg_wdata_i[sht_pkg::HalfW-1:0];
        sht_pkg::REG_ACK_WAIT:   cfg_d.ack_wait_ticks     = cfg_wdata_i;
        sht_pkg::REG_CONV_WAIT:  cfg_d.convert_wait_ticks = cfg_wdata_i;
        sht_pkg::REG_SETTLE:     cfg_d.settle_wait_ticks  = cfg_wdata_i;
        sht_pkg::REG_RESET_WAIT: cfg_d.reset_wait_ticks   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks     <= sht_pkg::HALF_BIT_RST;
      cfg_q.ack_wait_ticks     <= sht_pkg::ACK_WAIT_RST;
      cfg_q.convert_wait_ticks <= sht_pkg::CONV_RST;
      cfg_q.settle_wait_ticks  <= sht_pkg::SETTLE_RST;
      cfg_q.reset_wait_ticks   <= sht_pkg::RWAIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/sht_core.sv]
module sht_core #(
  parameter int unsigned WaitWidth   = sht_pkg::WAIT_WIDTH_DEF,
  parameter int unsigned ResetPulses = sht_pkg::RESET_PULSES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  sht_pkg::in_t  item_i,
  input  sht_pkg::cfg_t cfg_i,
  output sht_pkg::res_t res_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_RST_HI, PH_RST_LO, PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5,
    PH_W_PRE, PH_W_LO, PH_W_DAT, PH_W_HI, PH_ACK_LO, PH_ACK_HI, PH_ACK_WAIT,
    PH_SETTLE, PH_RWAIT, PH_CONV, PH_R_HI, PH_R_HI2, PH_R_LO, PH_R_AD, PH_R_AH
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [WaitWidth-1:0] tick_q, tick_d;
  logic [3:0]           bit_q, bit_d;
  logic [3:0]           pulse_q, pulse_d;
  logic [7:0]           shift_q, shift_d;
  logic [1:0]           byte_q, byte_d;
  logic [1:0]           op_q, op_d;
  logic [7:0]           held_q, held_d;
  logic [7:0]           high_q, high_d;
  logic [7:0]           low_q, low_d;
  logic                 err_q, err_d;
  logic                 done;

  logic [WaitWidth-1:0] half_n, ack_n, conv_n, settle_n, rwait_n, tick_dec;

  // Durations masked to the counter width; zero counts as one tick
  always_comb begin
    logic [sht_pkg::DurExtW-1:0] e_half, e_ack, e_conv, e_settle, e_rwait;
    e_half   = sht_pkg::DurExtW'(cfg_i.half_bit_ticks);
    e_ack    = sht_pkg::DurExtW'(cfg_i.ack_wait_ticks);
    e_conv   = sht_pkg::DurExtW'(cfg_i.convert_wait_ticks);
    e_settle = sht_pkg::DurExtW'(cfg_i.settle_wait_ticks);
    e_rwait  = sht_pkg::DurExtW'(cfg_i.reset_wait_ticks);
    half_n   = (e_half[WaitWidth-1:0] == '0)   ? WaitWidth'(1) : e_half[WaitWidth-1:0];
    ack_n    = (e_ack[WaitWidth-1:0] == '0)    ? WaitWidth'(1) : e_ack[WaitWidth-1:0];
    conv_n   = (e_conv[WaitWidth-1:0] == '0)   ? WaitWidth'(1) : e_conv[WaitWidth-1:0];
    settle_n = (e_settle[WaitWidth-1:0] == '0) ? WaitWidth'(1) : e_settle[WaitWidth-1:0];
    rwait_n  = (e_rwait[WaitWidth-1:0] == '0)  ? WaitWidth'(1) : e_rwait[WaitWidth-1:0];
  end

  assign tick_dec = tick_q - WaitWidth'(1);

  // Next state for one tick
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    pulse_d = pulse_q;
    shift_d = shift_q;
    byte_d  = byte_q;
    op_d    = op_q;
    held_d  = held_q;
    high_d  = high_q;
    low_d   = low_q;
    err_d   = err_q;
    done    = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (item_i.func != sht_pkg::FUNC_NONE) begin
        op_d    = item_i.func;
        shift_d = item_i.cmd_byte;
        held_d  = item_i.param_byte;
        err_d   = 1'b0;
        pulse_d = '0;
        bit_d   = '0;
        byte_d  = '0;
        phase_d = PH_RST_HI;
        tick_d  = half_n;
      end
    end else begin
      tick_d = tick_dec;
      if (tick_dec == '0) begin
        // Phase expired: move on; most phases last one half bit
        tick_d = half_n;
        case (phase_q)
          PH_RST_HI: phase_d = PH_RST_LO;
          PH_RST_LO: begin
            pulse_d = pulse_q + 4'd1;
            phase_d = (pulse_d < 4'(ResetPulses)) ? PH_RST_HI : PH_S0;
          end
          PH_S0: phase_d = PH_S1;
          PH_S1: phase_d = PH_S2;
          PH_S2: phase_d = PH_S3;
          PH_S3: phase_d = PH_S4;
          PH_S4: phase_d = PH_S5;
          PH_S5: begin
            bit_d   = '0;
            phase_d = PH_W_PRE;
          end
          PH_W_PRE: phase_d = PH_W_LO;
          PH_W_LO:  phase_d = PH_W_DAT;
          PH_W_DAT: phase_d = PH_W_HI;
          PH_W_HI: begin
            bit_d   = bit_q + 4'd1;
            phase_d = (bit_d >= 4'd8) ? PH_ACK_LO : PH_W_LO;
          end
          PH_ACK_LO: phase_d = PH_ACK_HI;
          PH_ACK_HI: begin
            if (item_i.data_in) err_d = 1'b1;
            phase_d = PH_ACK_WAIT;
            tick_d  = ack_n;
          end
          PH_ACK_WAIT: begin
            if (op_q == sht_pkg::FUNC_MEASURE) begin
              byte_d  = '0;
              phase_d = PH_CONV;
              tick_d  = conv_n;
            end else if (op_q == sht_pkg::FUNC_REG_WR) begin
              if (byte_q == 2'd0) begin
                phase_d = PH_SETTLE;
                tick_d  = settle_n;
              end else begin
                phase_d = PH_IDLE;
                tick_d  = '0;
                done    = 1'b1;
              end
            end else begin
              phase_d = PH_RWAIT;
              tick_d  = rwait_n;
            end
          end
          PH_SETTLE: begin
            shift_d = held_q;
            byte_d  = 2'd1;
            bit_d   = '0;
            phase_d = PH_W_PRE;
          end
          PH_RWAIT: begin
            phase_d = PH_IDLE;
            tick_d  = '0;
            done    = 1'b1;
          end
          PH_CONV: begin
            shift_d = '0;
            bit_d   = '0;
            phase_d = PH_R_HI;
          end
          PH_R_HI: begin
            shift_d = {shift_q[6:0], item_i.data_in};
            phase_d = PH_R_HI2;
          end
          PH_R_HI2: phase_d = PH_R_LO;
          PH_R_LO: begin
            bit_d = bit_q + 4'd1;
            if (bit_d >= 4'd8) begin
              if (byte_q == 2'd0) high_d = shift_q;
              else if (byte_q == 2'd1) low_d = shift_q;
              phase_d = PH_R_AD;
            end else begin
              phase_d = PH_R_HI;
            end
          end
          PH_R_AD: phase_d = PH_R_AH;
          PH_R_AH: begin
            byte_d = byte_q + 2'd1;
            if (byte_d == 2'd3) begin
              phase_d = PH_IDLE;
              tick_d  = '0;
              done    = 1'b1;
            end else begin
              shift_d = '0;
              bit_d   = '0;
              phase_d = PH_R_HI;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Pin levels and result fields from the updated state
  always_comb begin
    logic [2:0] cur_idx, prev_idx;
    logic       cur_bit, prev_bit, ack_lvl;
    cur_idx  = 3'd7 - bit_d[2:0];
    prev_idx = 3'd7 - (bit_d[2:0] - 3'd1);
    cur_bit  = shift_d[cur_idx];
    prev_bit = (bit_d == 4'd0) ? 1'b1 : shift_d[prev_idx];
    ack_lvl  = (byte_d < 2'd2) ? 1'b0 : 1'b1;
    res_o.sck      = 1'b0;
    res_o.data_out = 1'b1;
    res_o.data_oe  = 1'b0;
    case (phase_d)
      PH_RST_HI, PH_S1, PH_S5: begin
        res_o.sck = 1'b1; res_o.data_oe = 1'b1;
      end
      PH_RST_LO, PH_S0, PH_W_PRE: res_o.data_oe = 1'b1;
      PH_S2, PH_S4: begin
        res_o.sck = 1'b1; res_o.data_oe = 1'b1; res_o.data_out = 1'b0;
      end
      PH_S3: begin
        res_o.data_oe = 1'b1; res_o.data_out = 1'b0;
      end
      PH_W_LO: begin
        res_o.data_oe = 1'b1; res_o.data_out = prev_bit;
      end
      PH_W_DAT: begin
        res_o.data_oe = 1'b1; res_o.data_out = cur_bit;
      end
      PH_W_HI: begin
        res_o.sck = 1'b1; res_o.data_oe = 1'b1; res_o.data_out = cur_bit;
      end
      PH_ACK_HI, PH_R_HI, PH_R_HI2: res_o.sck = 1'b1;
      PH_R_AD: begin
        res_o.data_oe = 1'b1; res_o.data_out = ack_lvl;
      end
      PH_R_AH: begin
        res_o.sck = 1'b1; res_o.data_oe = 1'b1; res_o.data_out = ack_lvl;
      end
      default: ;
    endcase
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.ack_error = err_d;
    if (done && op_d == sht_pkg::FUNC_MEASURE) begin
      res_o.result_value = {high_d, low_d};
      res_o.check_byte   = shift_d;
    end else begin
      res_o.result_value = '0;
      res_o.check_byte   = '0;
    end
  end

  // State holds between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      pulse_q <= '0;
      shift_q <= '0;
      byte_q  <= '0;
      op_q    <= '0;
      held_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      pulse_q <= pulse_d;
      shift_q <= shift_d;
      byte_q  <= byte_d;
      op_q    <= op_d;
      held_q  <= held_d;
      high_q  <= high_d;
      low_q   <= low_d;
      err_q   <= err_d;
    end
  end

endmodule

[sv/sht_serial_sensor_master_top.sv]
// Channel  | Dir | Handshake     | Payload
// in_i     | in  | valid/ready   | func, cmd_byte, param_byte, data_in
// out_o    | out | valid/ready   | sck, data_out, data_oe, busy_res, done_res,
//          |     |               | result_value, check_byte, ack_error
// cfg      | in  | cfg_we_i only | cfg_idx_i, cfg_wdata_i
//
// One beat in, one beat out; a beat is taken every cycle while the output is not
// stalled, and passes the input register, then the result register after the tick logic.
// The sensor state advances only when the input register moves into the
// result register; a stalled output holds one beat there and one in the
// input register before ready drops.
// Reset is asynchronous, active low, and puts the bus master in idle with
// the register file at its defaults.
module sht_serial_sensor_master_top #(
  parameter int unsigned WaitWidth   = sht_pkg::WAIT_WIDTH_DEF,
  parameter int unsigned ResetPulses = sht_pkg::RESET_PULSES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sht_in_if.sink                        in_i,
  sht_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [sht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sht_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  sht_pkg::cfg_t cfg;
  sht_pkg::in_t  in_q;
  sht_pkg::res_t res, out_q;
  logic          in_v_q, out_v_q, step, in_rdy;

  assign step   = in_v_q && (!out_v_q || out_o.ready);
  assign in_rdy = !in_v_q || step;

  sht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sht_core #(
    .WaitWidth   (WaitWidth),
    .ResetPulses (ResetPulses)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.valid && in_rdy) begin
      in_v_q <= 1'b1;
    end else if (step) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      in_q.func       <= in_i.func;
      in_q.cmd_byte   <= in_i.cmd_byte;
      in_q.param_byte <= in_i.param_byte;
      in_q.data_in    <= in_i.data_in;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign in_i.ready         = in_rdy;
  assign out_o.valid        = out_v_q;
  assign out_o.sck          = out_q.sck;
  assign out_o.data_out     = out_q.data_out;
  assign out_o.data_oe      = out_q.data_oe;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.done_res     = out_q.done_res;
  assign out_o.result_value = out_q.result_value;
  assign out_o.check_byte   = out_q.check_byte;
  assign out_o.ack_error    = out_q.ack_error;

endmodule

[sv/sht_checker.sv]
module sht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        sck_i,
  input logic        data_out_i,
  input logic        data_oe_i,
  input logic        busy_i,
  input logic        done_i,
  input logic [15:0] result_i,
  input logic [7:0]  check_i
);

  // A finishing beat never shows the bus still busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> !busy_i)
    else $error("done beat reports busy");

  // Measurement fields are zero outside a done beat
  a_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !done_i |-> (result_i == 16'd0) && (check_i == 8'd0))
    else $error("result fields set outside done beat");

  // Idle pins: clock low, data released high
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_i |-> !sck_i && !data_oe_i && data_out_i)
    else $error("bus pins active while idle");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i) && $stable(busy_i))
    else $error("stalled result beat changed");

endmodule

bind sht_serial_sensor_master_top sht_checker u_sht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sck_i       (out_o.sck),
  .data_out_i  (out_o.data_out),
  .data_oe_i   (out_o.data_oe),
  .busy_i      (out_o.busy_res),
  .done_i      (out_o.done_res),
  .result_i    (out_o.result_value),
  .check_i     (out_o.check_byte)
);
